/* hw/rtl/key_code_to_onewire_rom_unit_defines.svh */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM unit: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef KEY_CODE_TO_ONEWIRE_ROM_UNIT_DEFINES_SVH
`define KEY_CODE_TO_ONEWIRE_ROM_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCOR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCOR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/kcor_pkg.sv */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM package
// Mode codes, constants, nibble functions and the CRC-8 column table.
// ----------------------------------------------------------------------------
package kcor_pkg;

   localparam int unsigned ROM_BYTES = 7;
   localparam int unsigned MSG_BITS  = ROM_BYTES * 8;

   localparam logic [7:0] FAMILY_CODE  = 8'h01;
   localparam logic [7:0] SERIES_MARK  = 8'h01;
   localparam logic [7:0] ALT_MASK     = 8'hAA;
   localparam logic [7:0] FIXED_CHECK  = 8'h9B;
   localparam logic [7:0] TABLE_MARK   = 8'h80;
   localparam logic [7:0] CRC_POLY     = 8'h8C;

   // Conversion modes carried in the action field.
   typedef enum logic [3:0] {
      ACT_COPY4 = 4'd0,
      ACT_C1    = 4'd1,
      ACT_C2    = 4'd2,
      ACT_C2ALT = 4'd3,
      ACT_C3    = 4'd4,
      ACT_C4    = 4'd5,
      ACT_C5    = 4'd6,
      ACT_C6    = 4'd7,
      ACT_C7    = 4'd8
   } action_type;

   // Mapping stage output: ROM bytes 0 to 6 and how byte 7 is formed.
   typedef struct packed {
      logic [MSG_BITS-1:0] rom_bytes;
      logic                use_crc;
      logic [7:0]          fixed_check;
   } map_result_type;

   typedef logic [7:0] crc_table_type [0:MSG_BITS-1];

   // Sixteen-entry nibble substitution.
   function automatic logic [3:0] nib_map(input logic [3:0] nib);
      logic [3:0] val;
      case (nib)
         4'h0: val = 4'hF;
         4'h1: val = 4'hB;
         4'h2: val = 4'h7;
         4'h3: val = 4'h3;
         4'h4: val = 4'hE;
         4'h5: val = 4'hA;
         4'h6: val = 4'h6;
         4'h7: val = 4'h2;
         4'h8: val = 4'hD;
         4'h9: val = 4'h9;
         4'hA: val = 4'h5;
         4'hB: val = 4'h1;
         4'hC: val = 4'hC;
         4'hD: val = 4'h8;
         4'hE: val = 4'h4;
         default: val = 4'h0;
      endcase
      return val;
   endfunction

   // Two bits to a one-hot nibble: 00 gives 8, 11 gives 1.
   function automatic logic [3:0] one_hot(input logic [1:0] two_bits);
      return 4'h8 >> two_bits;
   endfunction

   // A nibble becomes a byte of two one-hot nibbles.
   function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
      return {one_hot(nib[3:2]), one_hot(nib[1:0])};
   endfunction

   // The CRC is linear with a zero start value, so each message bit adds a
   // fixed column. This builds those columns at elaboration.
   function automatic crc_table_type build_crc_table();
      crc_table_type tbl;
      logic [7:0]    crc;
      logic [5:0]    pos;
      for (int p = 0; p < MSG_BITS; p++) begin
         pos = 6'(p);
         crc = 8'h00;
         for (int i = 0; i < ROM_BYTES; i++) begin
            if (3'(i) == pos[5:3]) begin
               crc = crc ^ (8'h01 << pos[2:0]);
            end
            for (int b = 0; b < 8; b++) begin
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
         end
         tbl[p] = crc;
      end
      return tbl;
   endfunction

   localparam crc_table_type CRC_COLUMNS = build_crc_table();

endpackage

/* hw/rtl/kcor_map.sv */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM: byte mapping
// Forms ROM bytes 0 to 6 from the mode and source code, and selects whether
// the check byte is computed or fixed.
// ----------------------------------------------------------------------------
module kcor_map (
   input  logic [3:0]              action,
   input  logic [31:0]             key_code,
   input  logic                    reverse_bytes,
   output kcor_pkg::map_result_type map_result
);
   import kcor_pkg::*;

   logic [7:0] s0;
   logic [7:0] s1;
   logic [7:0] s2;
   logic [7:0] s3;
   logic [7:0] alt_bits;
   logic [7:0] rb [0:ROM_BYTES-1];

   assign s0       = key_code[7:0];
   assign s1       = key_code[15:8];
   assign s2       = key_code[23:16];
   assign s3       = key_code[31:24];
   assign alt_bits = s1 & ALT_MASK;

   // Per-mode byte selection, then bytes 0 to 6 packed with byte 0 lowest.
   always_comb begin
      for (int i = 0; i < ROM_BYTES; i++) begin
         rb[i] = 8'h00;
      end
      rb[0]                  = FAMILY_CODE;
      map_result.use_crc     = 1'b1;
      map_result.fixed_check = 8'h00;
      case (action)
         ACT_COPY4: begin
            rb[1] = reverse_bytes ? s3 : s0;
            rb[2] = reverse_bytes ? s2 : s1;
            rb[3] = reverse_bytes ? s1 : s2;
            rb[4] = reverse_bytes ? s0 : s3;
         end
         ACT_C1: begin
            rb[1] = s0;
            rb[2] = s1;
            rb[3] = SERIES_MARK;
         end
         ACT_C2: begin
            rb[1] = s0 | {1'b0, s1[1], 6'b0};
            rb[2] = s1 | {7'b0, s1[3]};
            rb[3] = SERIES_MARK;
         end
         ACT_C2ALT: begin
            rb[1] = s0 | {1'b0, alt_bits[1], 6'b0};
            rb[2] = s1 | {3'b0, alt_bits[7], 1'b0, alt_bits[5], 1'b0, alt_bits[3]};
            rb[3] = SERIES_MARK;
         end
         ACT_C3: begin
            rb[1] = expand_nibble(s1[7:4]);
            rb[2] = expand_nibble(s1[3:0]);
            rb[3] = expand_nibble(s0[7:4]);
            rb[4] = expand_nibble(s0[3:0]);
         end
         ACT_C4: begin
            rb[1] = 8'hFF;
            rb[2] = 8'hFF;
            rb[3] = 8'hFF;
            rb[4] = 8'hFF;
            map_result.use_crc     = 1'b0;
            map_result.fixed_check = FIXED_CHECK;
         end
         ACT_C5: begin
            rb[1] = {nib_map(s0[7:4]), nib_map(s0[3:0])};
            rb[2] = {4'h0, nib_map(s1[3:0])};
            rb[3] = TABLE_MARK;
         end
         ACT_C6: begin
            rb[1] = {nib_map(s0[7:4]), nib_map(s0[3:0])};
            rb[2] = {nib_map(s1[7:4]), nib_map(s1[3:0])};
            rb[3] = TABLE_MARK;
         end
         ACT_C7: begin
            rb[1] = ~s0;
            rb[2] = ~s1;
         end
         default: begin
            // Unused modes give an all-zero image.
            rb[0]              = 8'h00;
            map_result.use_crc = 1'b0;
         end
      endcase
      for (int i = 0; i < ROM_BYTES; i++) begin
         map_result.rom_bytes[i*8 +: 8] = rb[i];
      end
   end

endmodule

/* hw/rtl/kcor_crc.sv */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM: CRC-8
// Reflected CRC-8 (polynomial 0x31, zero start) over seven ROM bytes, built
// as a flat XOR of precomputed columns.
// ----------------------------------------------------------------------------
module kcor_crc (
   input  logic [kcor_pkg::MSG_BITS-1:0] rom_bytes,
   output logic [7:0]                    crc
);
   import kcor_pkg::*;

   // Each set message bit contributes its column.
   always_comb begin
      crc = 8'h00;
      for (int i = 0; i < MSG_BITS; i++) begin
         if (rom_bytes[i]) begin
            crc = crc ^ CRC_COLUMNS[i];
         end
      end
   end

endmodule

/* hw/rtl/key_code_to_onewire_rom_unit.sv */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM unit
// Converts a source key code into an 8-byte one-wire ROM image: a family
// byte, a CRC-8 (or, in one mode, fixed) check byte; unused modes give zero.
//
// Usage:
//  - The request channel (req_) carries the 32-bit key code in tdata and the
//    mode and byte-reverse flag in tuser. A transfer happens when tvalid and
//    tready are both high at a rising clock edge.
//  - The response channel (rsp_) returns one 64-bit ROM image per request,
//    ROM byte 0 in the lowest bits and the check byte in the highest.
//  - The request is captured in an input register, mapped and checked in
//    one pass, and held in the result register.
//  - While the receiver does not stall, throughput is one item per cycle;
//    the mapping and the CRC XOR tree are a single pass between registers.
//  - When the receiver stalls, the result register holds its image and the
//    input register still takes one more item; req_tready falls only once
//    both registers are full.
//  - Reset empties both registers; no state is kept between items.
// ----------------------------------------------------------------------------
module key_code_to_onewire_rom_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key_code
   input  logic [4:0]  req_tuser,   // [3:0] action, [4] reverse_bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] rom_low, [63:32] rom_high
);
   import kcor_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [3:0]     action_ff;
   logic [31:0]    key_code_ff;
   logic           reverse_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic [63:0]    out_data_ff;
   logic [63:0]    out_data_in;
   logic           out_ready;
   logic           req_transfer;
   logic           out_load;
   map_result_type map_result;
   logic [7:0]     crc;

   // Handshake: each register takes new data when it is empty or draining.
   assign out_ready    = !out_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || out_ready;
   assign req_transfer = req_tvalid && req_tready;
   assign out_load     = in_valid_ff && out_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         action_ff   <= req_tuser[3:0];
         reverse_ff  <= req_tuser[4];
         key_code_ff <= req_tdata;
      end
   end

   // Byte mapping and check byte.
   kcor_map u_map (
      .action        (action_ff),
      .key_code      (key_code_ff),
      .reverse_bytes (reverse_ff),
      .map_result    (map_result)
   );

   kcor_crc u_crc (
      .rom_bytes (map_result.rom_bytes),
      .crc       (crc)
   );

   assign out_data_in = {(map_result.use_crc ? crc : map_result.fixed_check),
                         map_result.rom_bytes};

   // Result register payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* hw/rtl/kcor_checker.sv */
// ----------------------------------------------------------------------------
// Key code to one-wire ROM unit: port checker
// Watches the unit's ports and checks stall behaviour, readiness and the
// shape of the returned images.
// ----------------------------------------------------------------------------
`include "key_code_to_onewire_rom_unit_defines.svh"

module kcor_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // A stalled result keeps its image.
   `KCOR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // With no result waiting, the unit always takes a request.
   `KCOR_ASSERT_SAME(a_req_ready, clock, reset, !rsp_tvalid, req_tready, "request refused while response side empty")

   // Reset leaves no result pending in the next cycle.
   `KCOR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")

   // Every image starts with the family byte, or is all zero.
   `KCOR_ASSERT_SAME(a_family, clock, reset, rsp_tvalid && (rsp_tdata[7:0] != 8'h01), rsp_tdata == 64'h0, "bad family byte")

endmodule

bind key_code_to_onewire_rom_unit kcor_checker u_kcor_checker (.*);
